// ----- sv/clbt_pkg.sv -----
`default_nettype none
package clbt_pkg;

  // Operation codes carried on func_i.
  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  // Fixed port widths.
  localparam int unsigned ADDR_BITS   = 64;
  localparam int unsigned HPORT_BITS  = 16;

  // Epoch tag kept with each head entry. The all-ones tag never matches.
  localparam int unsigned EPOCH_BITS  = 4;
  localparam logic [EPOCH_BITS-1:0] EPOCH_DEAD = '1;
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = EPOCH_DEAD - 1'b1;

endpackage
`default_nettype wire

// ----- sv/chained_block_lookup_table_core.sv -----
// Block address to handle table. One command is taken while busy_o is low;
// its single result appears for one cycle with res_valid_o and cannot be held
// off. A lookup takes the bucket hash (a bit field when INSN_BYTES * BUCKETS
// is a power of two, otherwise the pipelined hash unit), one head memory
// read, and one pool memory read per chain node visited; an odd-address
// retry repeats this once.
// An insert takes the hash plus one head read. A flush and code 3 give their
// result straight from idle; every fifteenth flush then also sweeps the head
// memory, and the same sweep runs after reset with busy_o high.
`default_nettype none
module chained_block_lookup_table_core
  import clbt_pkg::*;
#(
  parameter int unsigned BUCKETS      = 1024,
  parameter int unsigned POOL_ENTRIES = 1024,
  parameter int unsigned INSN_BYTES   = 2,
  parameter int unsigned HANDLE_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [1:0]            func_i,
  input  wire logic [ADDR_BITS-1:0]  block_addr_i,
  input  wire logic [HPORT_BITS-1:0] handle_in_i,
  output logic                       res_valid_o,
  output logic                       hit_o,
  output logic [HPORT_BITS-1:0]      handle_out_o,
  output logic [1:0]                 status_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic                  cfg_data_i
);

  localparam int unsigned BW  = $clog2(BUCKETS);
  localparam int unsigned LW  = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned PIW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned HW  = (HANDLE_BITS < HPORT_BITS) ? HANDLE_BITS : HPORT_BITS;
  localparam int unsigned PEW = ADDR_BITS + HW + LW;
  localparam int unsigned HEW = EPOCH_BITS + PEW;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_HEAD  = 5'b01000,
    S_POOL  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic                   ins_q, ins_d;
  logic [ADDR_BITS-1:0]   cur_q, cur_d;
  logic [HW-1:0]          hin_q, hin_d;
  logic [BW-1:0]          b_q, b_d;
  logic [HEW-1:0]         head_q, head_d;
  logic [PIW-1:0]         n_q, n_d;
  logic [LW-1:0]          used_q, used_d;
  logic [EPOCH_BITS-1:0]  epoch_q, epoch_d;
  logic [BW-1:0]          clr_q, clr_d;
  logic                   retry_q;
  logic                   res_valid_q;
  logic                   hit_q;
  logic [HPORT_BITS-1:0]  hout_q;
  logic [1:0]             status_q;

  logic                   emit;
  logic                   e_hit;
  logic [HPORT_BITS-1:0]  e_hout;
  logic [1:0]             e_status;

  logic                   bk_start;
  logic                   bk_done;
  logic [BW-1:0]          bk_bucket;

  logic                   hd_we, hd_re;
  logic [BW-1:0]          hd_waddr, hd_raddr;
  logic [HEW-1:0]         hd_wdata, hd_rdata;
  logic                   pl_we, pl_re;
  logic [PIW-1:0]         pl_waddr, pl_raddr;
  logic [PEW-1:0]         pl_wdata, pl_rdata;

  logic [EPOCH_BITS-1:0]  h_ep;
  logic [ADDR_BITS-1:0]   h_addr, q_addr, p_addr;
  logic [HW-1:0]          h_hand, q_hand, p_hand;
  logic [LW-1:0]          h_link, q_link, p_link;
  logic [LW-1:0]          nxt_link, nxt_node;
  logic                   link_ok;

  // Field views of the head read data, the held head and the pool read data.
  assign h_ep   = hd_rdata[HEW-1 -: EPOCH_BITS];
  assign h_addr = hd_rdata[HW+LW +: ADDR_BITS];
  assign h_hand = hd_rdata[LW +: HW];
  assign h_link = hd_rdata[LW-1:0];
  assign q_addr = head_q[HW+LW +: ADDR_BITS];
  assign q_hand = head_q[LW +: HW];
  assign q_link = head_q[LW-1:0];
  assign p_addr = pl_rdata[HW+LW +: ADDR_BITS];
  assign p_hand = pl_rdata[LW +: HW];
  assign p_link = pl_rdata[LW-1:0];

  // Next chain link and whether it names a pool node.
  assign nxt_link = (state_q == S_HEAD) ? h_link : p_link;
  assign nxt_node = nxt_link - 1'b1;
  assign link_ok  = (nxt_link != '0) && (nxt_node < LW'(POOL_ENTRIES));

  clbt_bucket #(
    .BUCKETS    (BUCKETS),
    .INSN_BYTES (INSN_BYTES),
    .BW         (BW)
  ) u_bucket (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bk_start),
    .addr_i   (cur_d),
    .done_o   (bk_done),
    .bucket_o (bk_bucket)
  );

  clbt_ram #(.WIDTH(HEW), .DEPTH(BUCKETS), .AW(BW)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (hd_we),
    .waddr_i (hd_waddr),
    .wdata_i (hd_wdata),
    .re_i    (hd_re),
    .raddr_i (hd_raddr),
    .rdata_o (hd_rdata)
  );

  clbt_ram #(.WIDTH(PEW), .DEPTH(POOL_ENTRIES), .AW(PIW)) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (pl_we),
    .waddr_i (pl_waddr),
    .wdata_i (pl_wdata),
    .re_i    (pl_re),
    .raddr_i (pl_raddr),
    .rdata_o (pl_rdata)
  );

  // Command sequencer: hash, read head, walk chain, write back.
  always_comb begin
    state_d  = state_q;
    ins_d    = ins_q;
    cur_d    = cur_q;
    hin_d    = hin_q;
    b_d      = b_q;
    head_d   = head_q;
    n_d      = n_q;
    used_d   = used_q;
    epoch_d  = epoch_q;
    clr_d    = clr_q;
    emit     = 1'b0;
    e_hit    = 1'b0;
    e_hout   = '0;
    e_status = STATUS_DONE;
    bk_start = 1'b0;
    hd_we    = 1'b0;
    hd_waddr = b_q;
    hd_wdata = '0;
    hd_re    = 1'b0;
    hd_raddr = bk_bucket;
    pl_we    = 1'b0;
    pl_waddr = n_q;
    pl_wdata = '0;
    pl_re    = 1'b0;
    pl_raddr = PIW'(nxt_node);
    unique case (state_q)
      S_CLEAR: begin
        hd_we    = 1'b1;
        hd_waddr = clr_q;
        hd_wdata = {EPOCH_DEAD, {PEW{1'b0}}};
        clr_d    = clr_q + 1'b1;
        if (clr_q == BW'(BUCKETS - 1)) begin
          epoch_d = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cur_d = block_addr_i;
          hin_d = handle_in_i[HW-1:0];
          unique case (func_i)
            FUNC_LOOKUP, FUNC_INSERT: begin
              ins_d    = (func_i == FUNC_INSERT);
              bk_start = 1'b1;
              state_d  = S_HASH;
            end
            FUNC_FLUSH: begin
              emit   = 1'b1;
              used_d = '0;
              if (epoch_q == EPOCH_LAST) begin
                clr_d   = '0;
                state_d = S_CLEAR;
              end else begin
                epoch_d = epoch_q + 1'b1;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_HASH: begin
        if (bk_done) begin
          hd_re   = 1'b1;
          b_d     = bk_bucket;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        head_d = hd_rdata;
        if (ins_q) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (h_ep != epoch_q) begin
            hd_we    = 1'b1;
            hd_wdata = {epoch_q, cur_q, hin_q, {LW{1'b0}}};
          end else if (used_q == LW'(POOL_ENTRIES)) begin
            e_status = STATUS_FULL;
          end else begin
            // Push the old head into a fresh pool node.
            pl_we    = 1'b1;
            pl_waddr = PIW'(used_q);
            pl_wdata = {h_addr, h_hand, h_link};
            hd_we    = 1'b1;
            hd_wdata = {epoch_q, cur_q, hin_q, LW'(used_q + 1'b1)};
            used_d   = used_q + 1'b1;
          end
        end else if ((h_ep == epoch_q) && (h_addr == cur_q)) begin
          emit    = 1'b1;
          e_hit   = 1'b1;
          e_hout  = HPORT_BITS'(h_hand);
          state_d = S_IDLE;
        end else if ((h_ep == epoch_q) && link_ok) begin
          pl_re   = 1'b1;
          n_d     = PIW'(nxt_node);
          state_d = S_POOL;
        end else if (cur_q[0] && retry_q) begin
          cur_d    = {cur_q[ADDR_BITS-1:1], 1'b0};
          bk_start = 1'b1;
          state_d  = S_HASH;
        end else begin
          emit     = 1'b1;
          e_status = STATUS_MISS;
          state_d  = S_IDLE;
        end
      end
      S_POOL: begin
        if (p_addr == cur_q) begin
          // Move to front: swap the found node with the head.
          pl_we    = 1'b1;
          pl_wdata = {q_addr, q_hand, p_link};
          hd_we    = 1'b1;
          hd_wdata = {epoch_q, cur_q, p_hand, q_link};
          emit     = 1'b1;
          e_hit    = 1'b1;
          e_hout   = HPORT_BITS'(p_hand);
          state_d  = S_IDLE;
        end else if (link_ok) begin
          pl_re = 1'b1;
          n_d   = PIW'(nxt_node);
        end else if (cur_q[0] && retry_q) begin
          cur_d    = {cur_q[ADDR_BITS-1:1], 1'b0};
          bk_start = 1'b1;
          state_d  = S_HASH;
        end else begin
          emit     = 1'b1;
          e_status = STATUS_MISS;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      epoch_q     <= '0;
      used_q      <= '0;
      ins_q       <= 1'b0;
      retry_q     <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      epoch_q     <= epoch_d;
      used_q      <= used_d;
      ins_q       <= ins_d;
      res_valid_q <= emit;
      if (cfg_valid_i) begin
        retry_q <= cfg_data_i;
      end
    end
  end

  // Payload state.
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    hin_q    <= hin_d;
    b_q      <= b_d;
    head_q   <= head_d;
    n_q      <= n_d;
    hit_q    <= e_hit;
    hout_q   <= e_hout;
    status_q <= e_status;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign res_valid_o  = res_valid_q;
  assign hit_o        = hit_q;
  assign handle_out_o = hout_q;
  assign status_o     = status_q;

  // The pool allocator never runs past the pool.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= LW'(POOL_ENTRIES))
    else $error("pool allocation count beyond pool size");

  // Live entries never carry the dead epoch tag.
  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != EPOCH_DEAD)
    else $error("current epoch equals the dead tag");

  // An insert that pushes a node advances the allocator by one.
  a_push_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pl_we && (state_q == S_HEAD)) |=> (used_q == $past(used_q) + 1'b1))
    else $error("pool push without allocation");

  // A hit result always reports done status.
  a_hit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && hit_o) |-> (status_o == STATUS_DONE))
    else $error("hit with non-done status");

endmodule
`default_nettype wire

// ----- sv/clbt_ram.sv -----
`default_nettype none
module clbt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- sv/clbt_bucket.sv -----
`default_nettype none
module clbt_bucket
  import clbt_pkg::*;
#(
  parameter int unsigned BUCKETS    = 1024,
  parameter int unsigned INSN_BYTES = 2,
  parameter int unsigned BW         = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [ADDR_BITS-1:0] addr_i,
  output logic                      done_o,
  output logic      [BW-1:0]        bucket_o
);

  localparam int unsigned M    = BUCKETS * INSN_BYTES;
  localparam bit          POW2 = (M & (M - 1)) == 0;

  // Weight of hex digit j of the address: 16**j mod M, evaluated at elaboration.
  function automatic longint unsigned digit_weight(int unsigned j);
    longint unsigned w;
    w = 1;
    for (int unsigned i = 0; i < j; i++) begin
      w = (w * 16) % M;
    end
    return w;
  endfunction

  if (POW2) begin : g_shift
    localparam int unsigned SH = $clog2(INSN_BYTES);
    logic          done_q;
    logic [BW-1:0] bucket_q;

    // Both divisors are powers of two: the bucket is a bit field.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        bucket_q <= addr_i[SH +: BW];
      end
    end

    assign done_o   = done_q;
    assign bucket_o = bucket_q;
  end else begin : g_fold
    // The address is folded as sixteen hex digits, each scaled by its weight
    // 16**j mod M. The sum is brought below M by compare and subtract over two
    // stages and then divided by INSN_BYTES with a reciprocal multiply. The
    // unit is a five stage pipeline.
    localparam int unsigned     RW  = $clog2(M);
    localparam int unsigned     SW  = RW + 8;
    localparam int unsigned     NA  = ADDR_BITS / 4;
    localparam int unsigned     KSH = RW + 3;
    localparam int unsigned     QW  = RW + KSH + 1;
    localparam longint unsigned RCP = ((64'd1 << KSH) + INSN_BYTES - 1) / INSN_BYTES;

    logic [4:0]           vld_q;
    logic [ADDR_BITS-1:0] addr_q;
    logic [SW-1:0]        prod [NA];
    logic [SW-1:0]        s8 [8];
    logic [SW-1:0]        s4 [4];
    logic [SW-1:0]        sum_d, sum_q;
    logic [SW-1:0]        red_d, red_q;
    logic [SW-1:0]        low_d;
    logic [RW-1:0]        rem_q;
    logic [QW-1:0]        scaled;
    logic [BW-1:0]        bucket_q;

    // Each digit times its constant weight.
    for (genvar j = 0; j < NA; j++) begin : g_digit
      localparam logic [RW-1:0] WT = RW'(digit_weight(j));
      assign prod[j] = SW'(addr_q[4*j +: 4]) * SW'(WT);
    end

    // Adder tree over the scaled digits.
    always_comb begin
      for (int k = 0; k < 8; k++) begin
        s8[k] = prod[2*k] + prod[2*k+1];
      end
      for (int k = 0; k < 4; k++) begin
        s4[k] = s8[2*k] + s8[2*k+1];
      end
      sum_d = (s4[0] + s4[1]) + (s4[2] + s4[3]);
    end

    // Range reduction: the sum is below 256 * M, four steps per stage.
    always_comb begin
      red_d = sum_q;
      for (int k = 7; k >= 4; k--) begin
        if (red_d >= (SW'(M) << k)) begin
          red_d = red_d - (SW'(M) << k);
        end
      end
      low_d = red_q;
      for (int k = 3; k >= 0; k--) begin
        if (low_d >= (SW'(M) << k)) begin
          low_d = low_d - (SW'(M) << k);
        end
      end
    end

    // Exact division of the remainder by INSN_BYTES.
    assign scaled = QW'(rem_q) * QW'(RCP);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= '0;
      end else begin
        vld_q <= {vld_q[3:0], start_i};
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        addr_q <= addr_i;
      end
      if (vld_q[0]) begin
        sum_q <= sum_d;
      end
      if (vld_q[1]) begin
        red_q <= red_d;
      end
      if (vld_q[2]) begin
        rem_q <= RW'(low_d);
      end
      if (vld_q[3]) begin
        bucket_q <= BW'(scaled >> KSH);
      end
    end

    assign done_o   = vld_q[4];
    assign bucket_o = bucket_q;
  end

endmodule
`default_nettype wire

// ----- test/tb_chained_block_lookup_table_core.sv -----
`timescale 1ns / 1ps
module tb_chained_block_lookup_table_core;
  import clbt_pkg::*;

  localparam int unsigned NBUCKETS = 1024;
  localparam int unsigned NPOOL = 1024;
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam longint unsigned CYCLE_LIMIT = 6000000;

  // Expected outcome of one command.
  typedef struct packed {
    logic hit;
    logic [15:0] handle;
    logic [1:0] status;
  } outcome_t;

  // Scoreboard: mirrors the table and queues expected outcomes.
  class lookup_scoreboard;
    bit retry_even;
    bit head_valid[NBUCKETS];
    logic [63:0] head_addr[NBUCKETS];
    logic [15:0] head_handle[NBUCKETS];
    int unsigned head_link[NBUCKETS];
    logic [63:0] pool_addr[NPOOL];
    logic [15:0] pool_handle[NPOOL];
    int unsigned pool_link[NPOOL];
    int unsigned pool_used;
    outcome_t pending[$];
    int mismatches;

    function new();
      retry_even = 1'b1;
      mismatches = 0;
      flush_table();
    endfunction

    function void flush_table();
      foreach (head_valid[i]) begin
        head_valid[i] = 1'b0;
        head_link[i] = 0;
      end
      pool_used = 0;
    endfunction

    // Head check, then chain walk with move to front on a chain hit.
    function bit search(logic [63:0] a, output logic [15:0] h);
      int unsigned b;
      int unsigned link;
      int unsigned n;
      logic [15:0] th;
      b = a[10:1];
      h = '0;
      if (!head_valid[b]) return 1'b0;
      if (head_addr[b] == a) begin
        h = head_handle[b];
        return 1'b1;
      end
      link = head_link[b];
      for (int steps = 0; steps < NPOOL && link != 0; steps++) begin
        n = link - 1;
        if (n >= NPOOL) return 1'b0;
        if (pool_addr[n] == a) begin
          th = pool_handle[n];
          pool_addr[n] = head_addr[b];
          pool_handle[n] = head_handle[b];
          head_addr[b] = a;
          head_handle[b] = th;
          h = th;
          return 1'b1;
        end
        link = pool_link[n];
      end
      return 1'b0;
    endfunction

    function bit insert(logic [63:0] a, logic [15:0] h);
      int unsigned b;
      b = a[10:1];
      if (head_valid[b]) begin
        if (pool_used >= NPOOL) return 1'b0;
        pool_addr[pool_used] = head_addr[b];
        pool_handle[pool_used] = head_handle[b];
        pool_link[pool_used] = head_link[b];
        head_link[b] = pool_used + 1;
        pool_used++;
      end
      head_valid[b] = 1'b1;
      head_addr[b] = a;
      head_handle[b] = h;
      return 1'b1;
    endfunction

    // Called for every accepted command beat.
    function void note_command(logic [1:0] func, logic [63:0] a, logic [15:0] hin);
      outcome_t o;
      logic [15:0] h;
      bit found;
      o = '{hit: 1'b0, handle: '0, status: STATUS_DONE};
      if (func == FUNC_LOOKUP) begin
        found = search(a, h);
        if (!found && a[0] && retry_even) found = search({a[63:1], 1'b0}, h);
        if (found) begin
          o.hit = 1'b1;
          o.handle = h;
        end else begin
          o.status = STATUS_MISS;
        end
      end else if (func == FUNC_INSERT) begin
        if (!insert(a, hin)) o.status = STATUS_FULL;
      end else if (func == FUNC_FLUSH) begin
        flush_table();
      end
      pending.push_back(o);
    endfunction

    // Called for every result beat.
    function void check_result(logic hit, logic [15:0] handle, logic [1:0] status);
      outcome_t e;
      if (pending.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result hit=%0b handle=%h status=%0d",
                   $realtime, hit, handle, status);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit || handle !== e.handle || status !== e.status) begin
        if (mismatches < 10)
          $display("%0t: expected hit=%0b handle=%h status=%0d, got hit=%0b handle=%h status=%0d",
                   $realtime, e.hit, e.handle, e.status, hit, handle, status);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] func_i = FUNC_NOP;
  logic [63:0] block_addr_i = '0;
  logic [15:0] handle_in_i = '0;
  logic res_valid_o;
  logic hit_o;
  logic [15:0] handle_out_o;
  logic [1:0] status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i = 1'b0;

  lookup_scoreboard table_sb = new();
  logic [63:0] upper_set[4];
  logic [63:0] crowd_addrs[$];
  longint unsigned cycles = 0;

  chained_block_lookup_table_core i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .func_i(func_i), .block_addr_i(block_addr_i), .handle_in_i(handle_in_i),
    .res_valid_o(res_valid_o), .hit_o(hit_o), .handle_out_o(handle_out_o),
    .status_o(status_o), .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Watch the command, result and config channels at the rising edge and end the run on a timeout.
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni) begin
      if (start_i && !busy_o) table_sb.note_command(func_i, block_addr_i, handle_in_i);
      if (res_valid_o) table_sb.check_result(hit_o, handle_out_o, status_o);
      if (cfg_valid_i && cfg_ready_o) table_sb.retry_even = cfg_data_i;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Issue one command beat and hold it until the block takes it.
  task automatic send_command(logic [1:0] func, logic [63:0] a, logic [15:0] h);
    @(negedge clk_i);
    start_i <= 1'b1;
    func_i <= func;
    block_addr_i <= a;
    handle_in_i <= h;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
  endtask

  // Drop start for a number of cycles.
  task automatic idle_sender(int unsigned n);
    if (n == 0) return;
    @(negedge clk_i);
    start_i <= 1'b0;
    func_i <= FUNC_NOP;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Wait until every expected result has come and the block is idle.
  task automatic wait_drained();
    idle_sender(1);
    while (table_sb.pending.size() != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic write_retry(logic value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Addresses crowd into a few buckets with a few upper parts, so hits,
  // chains and odd-address retries are common.
  function automatic logic [63:0] pick_addr();
    logic [63:0] a;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    a = upper_set[$urandom_range(0, 3)] & ~64'h7FF;
    a[10:1] = 10'($urandom_range(0, 15));
    a[0] = 1'($urandom_range(0, 1));
    return a;
  endfunction

  task automatic random_burst(int unsigned count);
    int unsigned left;
    int unsigned r;
    logic [1:0] func;
    left = count;
    while (left > 0) begin
      for (int unsigned k = $urandom_range(1, 12); k > 0 && left > 0; k--) begin
        r = $urandom_range(0, 99);
        func = (r < 55) ? FUNC_LOOKUP : (r < 94) ? FUNC_INSERT :
               (r < 97) ? FUNC_FLUSH : FUNC_NOP;
        send_command(func, pick_addr(), 16'($urandom));
        left--;
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
    end
  endtask

  initial begin
    logic [63:0] a;
    foreach (upper_set[i]) upper_set[i] = {$urandom, $urandom};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every operation, field extremes, retry and move to front.
    write_retry(1'b1);
    send_command(FUNC_NOP, '1, '1);
    send_command(FUNC_LOOKUP, '0, '0);
    send_command(FUNC_INSERT, '1, 16'hFFFF);
    send_command(FUNC_LOOKUP, '1, '0);
    send_command(FUNC_INSERT, '0, '0);
    send_command(FUNC_LOOKUP, 64'h1, '0);
    send_command(FUNC_INSERT, 64'h2000, 16'h1234);
    send_command(FUNC_INSERT, 64'h4000, 16'h5678);
    send_command(FUNC_INSERT, 64'h6000, 16'h9ABC);
    send_command(FUNC_LOOKUP, 64'h2000, '0);
    send_command(FUNC_LOOKUP, 64'h2000, '0);
    send_command(FUNC_LOOKUP, 64'h4001, '0);
    send_command(FUNC_INSERT, 64'h2000, 16'h0001);
    send_command(FUNC_LOOKUP, 64'h2000, '0);
    send_command(FUNC_LOOKUP, 64'h8000, '0);
    send_command(FUNC_FLUSH, '1, '1);
    send_command(FUNC_LOOKUP, 64'h6000, '0);
    random_burst(200);

    write_retry(1'b0);
    send_command(FUNC_INSERT, 64'h10, 16'h00AA);
    send_command(FUNC_LOOKUP, 64'h11, '0);
    random_burst(200);

    // Build long chains in a few buckets, then walk them.
    write_retry(1'b1);
    send_command(FUNC_FLUSH, '0, '0);
    repeat (300) begin
      a = {$urandom, $urandom};
      a[10:1] = 10'($urandom_range(0, 7));
      a[0] = 1'b0;
      crowd_addrs.push_back(a);
      send_command(FUNC_INSERT, a, 16'($urandom));
    end
    repeat (10)
      send_command(FUNC_LOOKUP,
                   crowd_addrs[$urandom_range(0, 299)] | 64'($urandom_range(0, 1)), '0);
    send_command(FUNC_FLUSH, '0, '0);
    random_burst(20);

    // Drain and report.
    wait_drained();
    repeat (50) @(negedge clk_i);
    if (table_sb.mismatches == 0 && table_sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
